### rtl/swm_pkg.sv
// Shared types, constants and command codes for the sliding window median filter.
// No dependencies; every other file of the block uses this package.
package swm_pkg;

    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 32;
    localparam int RESULT_BITS = SAMPLE_BITS + 1;
    localparam int CFG_BITS    = 7;
    localparam int IDX_BITS    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_BITS    = $clog2(WINDOW_MAX + 1);

    localparam logic [CFG_BITS-1:0] LEN_RESET = CFG_BITS'(3);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [RESULT_BITS-1:0] result_t;
    typedef logic [IDX_BITS-1:0]           idx_t;
    typedef logic [CNT_BITS-1:0]           cnt_t;
    typedef logic [CFG_BITS-1:0]           cfg_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TRIM,
        ST_PICK,
        ST_SUM
    } state_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t op;
        logic     restart;
        sample_t  new_value;
        sample_t  old_value;
    } cell_cmd_t;

    // what a cell shows its neighbors and the top level
    typedef struct packed {
        logic    valid;
        logic    le;
        sample_t value;
        idx_t    age;
    } cell_view_t;

    // controller requests toward the chain and the median pick
    typedef struct packed {
        cell_op_t op;
        logic     restart;
        sample_t  new_value;
        idx_t     drop_age;
        idx_t     lo_idx;
        idx_t     hi_idx;
    } ctrl_cmd_t;

    // the two middle values picked from the chain
    typedef struct packed {
        sample_t lo;
        sample_t hi;
    } pick_t;

endpackage

### rtl/swm_in_if.sv
// Sample channel: valid/ready handshake carrying one sample and a restart flag.
// Depends on swm_pkg for the sample type.
interface swm_in_if;
    logic             valid;
    logic             ready;
    swm_pkg::sample_t sample;
    logic             restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

### rtl/swm_out_if.sv
// Result channel: valid/ready handshake carrying twice the window median.
// Depends on swm_pkg for the result type.
interface swm_out_if;
    logic             valid;
    logic             ready;
    swm_pkg::result_t median_doubled;

    modport source (output valid, output median_doubled, input ready);
    modport sink   (input valid, input median_doubled, output ready);
endinterface

### rtl/swm_cell.sv
// One cell of the sorted chain: holds a sample, its age and a valid bit.
// Depends on swm_pkg for the command and view structs.
module swm_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  swm_pkg::cell_cmd_t     cmd,
    input  swm_pkg::cell_view_t    left,
    input  swm_pkg::cell_view_t    right,
    output swm_pkg::cell_view_t    view
);
    import swm_pkg::*;

    sample_t value_reg, value_next;
    idx_t    age_reg, age_next;
    logic    valid_reg, valid_next;
    logic    live;
    logic    le;
    logic    at_or_after;

    always_comb
    begin
        live        = valid_reg && !cmd.restart;
        le          = live && (value_reg <= cmd.new_value);
        at_or_after = valid_reg && (value_reg >= cmd.old_value);

        view.valid = live;
        view.le    = le;
        view.value = value_reg;
        view.age   = age_reg;

        value_next = value_reg;
        age_next   = age_reg;
        valid_next = valid_reg;

        case (cmd.op)
            CELL_INSERT:
            begin
                if (le)
                begin
                    age_next   = age_reg + idx_t'(1);
                    valid_next = 1'b1;
                end
                else if (left.le)
                begin
                    // insertion point: first cell holding a larger value or empty
                    value_next = cmd.new_value;
                    age_next   = '0;
                    valid_next = 1'b1;
                end
                else
                begin
                    value_next = left.value;
                    age_next   = left.age + idx_t'(1);
                    valid_next = left.valid;
                end
            end
            CELL_REMOVE:
            begin
                // oldest of equals sits first in its run, so shift from there on
                if (at_or_after)
                begin
                    value_next = right.value;
                    age_next   = right.age;
                    valid_next = right.valid;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        age_reg   <= age_next;
    end

endmodule

### rtl/swm_ctrl.sv
// Sequencer: window length register, fill count, handshakes and result register.
// Depends on swm_pkg and the swm_in_if / swm_out_if interfaces.
module swm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  swm_pkg::cfg_t       cfg_wdata,
    swm_in_if.sink              sample_ch,
    swm_out_if.source           median_ch,
    input  swm_pkg::pick_t      pick,
    output swm_pkg::ctrl_cmd_t  cmd
);
    import swm_pkg::*;

    state_t  state_reg, state_next;
    cfg_t    window_length_reg;
    cnt_t    fill_reg, fill_next;
    cnt_t    len;
    cnt_t    len_m1;
    cnt_t    fill_dec;
    sample_t lo_reg, hi_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg;
    logic    out_free;
    logic    out_load;
    logic    accept;

    // zero acts as one, anything above the chain length as the chain length
    always_comb
    begin
        if (window_length_reg == '0)
            len = cnt_t'(1);
        else if (window_length_reg > CFG_BITS'(WINDOW_MAX))
            len = cnt_t'(WINDOW_MAX);
        else
            len = cnt_t'(window_length_reg);
        len_m1   = len - cnt_t'(1);
        fill_dec = fill_reg - cnt_t'(1);
    end

    assign sample_ch.ready       = (state_reg == ST_IDLE);
    assign accept                = sample_ch.valid && sample_ch.ready;
    assign median_ch.valid       = out_valid_reg;
    assign median_ch.median_doubled = out_data_reg;
    assign out_free              = !out_valid_reg || median_ch.ready;

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        out_load      = 1'b0;
        cmd.op        = CELL_HOLD;
        cmd.restart   = 1'b0;
        cmd.new_value = sample_ch.sample;
        cmd.drop_age  = fill_dec[IDX_BITS-1:0];
        cmd.lo_idx    = IDX_BITS'(len_m1 >> 1);
        cmd.hi_idx    = IDX_BITS'(len >> 1);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.op      = CELL_INSERT;
                    cmd.restart = sample_ch.restart;
                    fill_next   = (sample_ch.restart ? cnt_t'(0) : fill_reg) + cnt_t'(1);
                    state_next  = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                if (fill_reg > len)
                begin
                    cmd.op    = CELL_REMOVE;
                    fill_next = fill_dec;
                end
                else if (fill_reg < len)
                    state_next = ST_IDLE;
                else
                    state_next = ST_PICK;
            end
            ST_PICK:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    cmd.op     = CELL_REMOVE;
                    fill_next  = fill_dec;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (median_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            fill_reg          <= '0;
            out_valid_reg     <= 1'b0;
            window_length_reg <= LEN_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                window_length_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PICK)
        begin
            lo_reg <= pick.lo;
            hi_reg <= pick.hi;
        end
        if (out_load)
            out_data_reg <= result_t'(lo_reg) + result_t'(hi_reg);
    end

endmodule

### rtl/sliding_window_median.sv
// Sliding window median top level; uses swm_pkg, swm_in_if, swm_out_if, swm_cell, swm_ctrl.
// Steps per sample: insert, then trim (one remove for each sample dropped after the window
// length was lowered); with a full window also pick the middle values and sum them.
// A new sample is taken only in idle, after the last one is through these steps;
// the sum step also removes the oldest sample and waits while the sink stalls.
// Reset (rst_n, async, active low) empties the window and sets the window length to 3.
module sliding_window_median (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  swm_pkg::cfg_t cfg_wdata,
    swm_in_if.sink        sample_ch,
    swm_out_if.source     median_ch
);
    import swm_pkg::*;

    // The window lives in a row of cells kept in ascending order, cell 0 the
    // smallest. Each cell also carries its age (how many samples arrived after
    // it), so the oldest sample is the valid cell whose age is fill - 1.
    //
    // Insert: every cell decides locally from its own compare and its left
    // neighbor's whether to keep, take the new sample, or take the left value.
    // Equal values stay in arrival order, oldest first.
    //
    // Remove: the oldest value is found by a one-hot select on age; every cell
    // at or above that value takes its right neighbor. Because the oldest of a
    // run of equal values sits first in the run, this drops exactly that entry.

    ctrl_cmd_t  ctrl_cmd;
    cell_cmd_t  cell_cmd;
    pick_t      pick;
    cell_view_t views [WINDOW_MAX];
    cell_view_t left_edge;
    cell_view_t right_edge;
    sample_t    old_value;

    always_comb
    begin
        left_edge       = '0;
        left_edge.le    = 1'b1;   // lets cell 0 take the new sample
        right_edge      = '0;     // empty cell shifted in from the far end
    end

    // one-hot selects across the chain: oldest entry and the two middle entries
    always_comb
    begin
        old_value = '0;
        pick.lo   = '0;
        pick.hi   = '0;
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            if (views[i].valid && (views[i].age == ctrl_cmd.drop_age))
                old_value = old_value | views[i].value;
            if (idx_t'(i) == ctrl_cmd.lo_idx)
                pick.lo = pick.lo | views[i].value;
            if (idx_t'(i) == ctrl_cmd.hi_idx)
                pick.hi = pick.hi | views[i].value;
        end
    end

    always_comb
    begin
        cell_cmd.op        = ctrl_cmd.op;
        cell_cmd.restart   = ctrl_cmd.restart;
        cell_cmd.new_value = ctrl_cmd.new_value;
        cell_cmd.old_value = old_value;
    end

    swm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sample_ch (sample_ch),
        .median_ch (median_ch),
        .pick      (pick),
        .cmd       (ctrl_cmd)
    );

    for (genvar g = 0; g < WINDOW_MAX; g++)
    begin : g_cell
        cell_view_t left_view;
        cell_view_t right_view;

        if (g == 0)
        begin : g_first
            assign left_view = left_edge;
        end
        else
        begin : g_inner_l
            assign left_view = views[g-1];
        end

        if (g == WINDOW_MAX - 1)
        begin : g_last
            assign right_view = right_edge;
        end
        else
        begin : g_inner_r
            assign right_view = views[g+1];
        end

        swm_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cell_cmd),
            .left  (left_view),
            .right (right_view),
            .view  (views[g])
        );
    end

endmodule

### rtl/swm_checker.sv
// Port-level checks for sliding_window_median, attached by the bind below.
// Depends on swm_pkg for the result type.
module swm_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input swm_pkg::result_t out_data
);
    logic in_take;

    assign in_take = in_valid && in_ready;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(out_data))
        else $error("result changed while stalled");

    // one sample at a time: the sequencer leaves idle after each transaction
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> !in_ready)
        else $error("sample port ready right after a transaction");

    // a new result needs insert, trim and pick first
    a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (!$past(in_take, 1) && !$past(in_take, 2)))
        else $error("result appeared too soon after a sample");

endmodule

bind sliding_window_median swm_checker u_swm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample_ch.valid),
    .in_ready  (sample_ch.ready),
    .out_valid (median_ch.valid),
    .out_ready (median_ch.ready),
    .out_data  (median_ch.median_doubled)
);

### tb/sv/swm_median_checker.sv
// Checker for the sliding window median filter: tracks the window, predicts medians, compares.
// Depends on swm_pkg, swm_in_if and swm_out_if.
`timescale 1ns / 100ps

module swm_median_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  swm_pkg::cfg_t cfg_wdata,
    swm_in_if             sample_ch,
    swm_out_if            median_ch,
    output int            fail_count,
    output int            pending
);
    import swm_pkg::*;

    cfg_t    length_reg;
    sample_t window_arrival[$];   // held samples, oldest first
    sample_t window_sorted[$];    // same samples, ascending
    result_t medians_due[$];
    int      errors;

    // register value to number of samples held
    function automatic int unsigned span_of(cfg_t v);
        if (v == '0)
            return 1;
        if (v > WINDOW_MAX)
            return WINDOW_MAX;
        return 32'(v);
    endfunction

    function automatic void retire_oldest();
        sample_t gone;
        int      pos;
        gone = window_arrival.pop_front();
        pos  = 0;
        while (pos < window_sorted.size() && window_sorted[pos] != gone)
            pos++;
        if (pos < window_sorted.size())
            window_sorted.delete(pos);
    endfunction

    function automatic void advance_window(sample_t s, logic restart);
        int unsigned span;
        int          pos;
        sample_t     lo;
        sample_t     hi;
        span = span_of(length_reg);
        if (restart)
        begin
            window_arrival.delete();
            window_sorted.delete();
        end
        window_arrival.insert(window_arrival.size(), s);
        pos = 0;
        while (pos < window_sorted.size() && window_sorted[pos] <= s)
            pos++;
        window_sorted.insert(pos, s);
        // also trims the window after the length was lowered
        while (window_arrival.size() > span)
            retire_oldest();
        if (window_arrival.size() == span)
        begin
            // odd span: both picks hit the middle, giving twice the median
            lo = window_sorted[(span - 1) / 2];
            hi = window_sorted[span / 2];
            medians_due.insert(medians_due.size(),
                               {lo[SAMPLE_BITS-1], lo} + {hi[SAMPLE_BITS-1], hi});
            retire_oldest();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            length_reg = LEN_RESET;
            window_arrival.delete();
            window_sorted.delete();
            medians_due.delete();
            errors = 0;
        end
        else
        begin
            if (median_ch.valid === 1'b1 && median_ch.ready === 1'b1)
            begin
                if (medians_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: median_doubled mismatch, expected none, actual %0d",
                             $time, median_ch.median_doubled);
                end
                else
                begin
                    want = medians_due.pop_front();
                    if (median_ch.median_doubled !== want)
                    begin
                        errors++;
                        $display("%0t: median_doubled mismatch, expected %0d, actual %0d",
                                 $time, want, median_ch.median_doubled);
                    end
                end
            end
            if (cfg_we === 1'b1)
                length_reg = cfg_wdata;
            if (sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1)
                advance_window(sample_ch.sample, sample_ch.restart);
        end
        fail_count <= errors;
        pending    <= medians_due.size();
    end

endmodule

### tb/sv/sliding_window_median_tb.sv
// Top of the sliding window median testbench: clock, reset, stimulus, result stalls, verdict.
// Depends on swm_pkg, swm_in_if, swm_out_if, sliding_window_median and swm_median_checker.
`timescale 1ns / 100ps

module sliding_window_median_tb;
    import swm_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    // covers the result path plus a full trim after the length drops to one
    localparam int SETTLE_CYCLES = 100;

    localparam sample_t S_MAX = sample_t'(32'h7FFF_FFFF);
    localparam sample_t S_MIN = sample_t'(32'h8000_0000);

    // window lengths of the random phases; 0, 127 and 65 are the out-of-range settings
    localparam int PHASE_LEN [13] = '{64, 3, 1, 127, 7, 4, 65, 2, 6, 0, 9, 16, 33};

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    cfg_t cfg_wdata;

    bit src_gaps_on;
    bit sink_stalls_on;

    int fail_count;
    int pending_medians;
    int cycle_count = 0;

    swm_in_if  sample_ch ();
    swm_out_if median_ch ();

    sliding_window_median i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sample_ch (sample_ch),
        .median_ch (median_ch)
    );

    // watches both channels and the config port, predicts every median
    swm_median_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .sample_ch  (sample_ch),
        .median_ch  (median_ch),
        .fail_count (fail_count),
        .pending    (pending_medians)
    );

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a missing median ends the run here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Idle length for either side: mostly none, often a few cycles, rarely a long one.
    function automatic int unsigned idle_cycles(bit enabled);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!enabled || roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mix of full-range values, a narrow band that gives many duplicates,
    // the extremes, and repeats of the last sample.
    function automatic sample_t next_sample(sample_t prev);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return sample_t'($urandom);
        if (roll < 70)
            return sample_t'(int'($urandom_range(0, 16)) - 8);
        if (roll < 85)
        begin
            case ($urandom_range(0, 3))
                0:       return S_MAX - sample_t'($urandom_range(0, 2));
                1:       return S_MIN + sample_t'($urandom_range(0, 2));
                2:       return '0;
                default: return '1;
            endcase
        end
        return prev;
    endfunction

    // Result side: ready drops for random stretches while stalls are enabled.
    initial
    begin
        int unsigned hold;
        hold = 0;
        median_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold == 0)
                hold = idle_cycles(sink_stalls_on);
            if (hold > 0)
            begin
                median_ch.ready <= 1'b0;
                hold--;
            end
            else
            begin
                median_ch.ready <= 1'b1;
            end
        end
    end

    // One sample transaction. valid stays high into the next call when there is no gap,
    // so each edge sees a single assignment to it.
    task automatic send_sample(sample_t s, logic restart);
        int unsigned gap;
        gap = idle_cycles(src_gaps_on);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.sample  <= s;
        sample_ch.restart <= restart;
        @(posedge clk);
        while (sample_ch.ready !== 1'b1)
            @(posedge clk);
    endtask

    // Stop sending, wait for every predicted median, then let trims finish.
    // The extra edge first lets the checker count the last accepted sample.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_medians != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(cfg_t v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Stimulus and verdict
    initial
    begin
        sample_t     value;
        int unsigned count;

        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= LEN_RESET;
        sample_ch.valid   <= 1'b0;
        sample_ch.sample  <= '0;
        sample_ch.restart <= 1'b0;
        src_gaps_on       = 1'b0;
        sink_stalls_on    <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset length 3: extremes, duplicates, restart mid-window.
        send_sample(S_MAX, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample('0, 1'b1);
        send_sample('1, 1'b0);
        send_sample(sample_t'(1), 1'b0);
        send_sample(sample_t'(5), 1'b0);
        send_sample(sample_t'(5), 1'b0);
        settle();

        // Even window: largest and smallest sums, and a half value.
        write_length(cfg_t'(2));
        send_sample(S_MAX, 1'b1);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample(S_MIN, 1'b0);
        settle();

        // Length zero acts as one; the held sample gets trimmed on the next one.
        write_length('0);
        send_sample(S_MIN, 1'b0);
        send_sample('1, 1'b0);
        send_sample(S_MAX, 1'b0);

        // Random phases. No restart at a phase start, so a shorter length
        // meets a window that still holds samples from the phase before.
        value = '0;
        foreach (PHASE_LEN[p])
        begin
            settle();
            write_length(cfg_t'(PHASE_LEN[p]));
            src_gaps_on    = p[0];
            sink_stalls_on <= p[1];
            count = (PHASE_LEN[p] > 32) ? 150 : 80;
            repeat (count)
            begin
                value = next_sample(value);
                send_sample(value, $urandom_range(0, 49) == 0);
            end
        end
        settle();

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sliding_window_median.f
rtl/swm_pkg.sv
rtl/swm_in_if.sv
rtl/swm_out_if.sv
rtl/swm_cell.sv
rtl/swm_ctrl.sv
rtl/sliding_window_median.sv
rtl/swm_checker.sv
tb/sv/swm_median_checker.sv
tb/sv/sliding_window_median_tb.sv
